// ===== sv/ltht_pkg.sv =====
// ----------------------------------------------------------------------------
// ltht_pkg
// Shared types and constants for the LRU TLB hit tracker.
// ----------------------------------------------------------------------------
package ltht_pkg;

  localparam int DEF_ENTRIES = 64;

  localparam int ADDR_W    = 32;
  localparam int PAGE_OFS  = 10;
  localparam int TAG_W     = 22;
  localparam int PKB_W     = 11;
  localparam int CAP_CFG_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [PKB_W-1:0]     PAGE_KB_RESET = PKB_W'(4);
  localparam logic [CAP_CFG_W-1:0] CAP_RESET     = CAP_CFG_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE_KB   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = CFG_IDX_W'(1);

  typedef struct packed {
    logic lookup;
    logic update;
  } ltht_cmd_t;

endpackage

// ===== sv/lru_tlb_hit_tracker.sv =====
// ----------------------------------------------------------------------------
// lru_tlb_hit_tracker
// Fully associative TLB with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each address transfer is reduced to a page number by dividing the address
// by 1024 times the page size register, then looked up among the valid
// entries; one transfer on the output reports hit or miss and the table is
// updated in LRU order. An accepted item passes through the serial divider,
// one quotient bit a cycle, then a lookup state, an update state and a hold
// state that loads the output register. The input is ready again after that
// load; a result that is still held on the output delays the load of the
// next one for as long as the receiver stalls. Items are handled one at a
// time; a new item is taken while the previous result still waits on the
// output.
module lru_tlb_hit_tracker
  import ltht_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [31:0] address
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [0] hit, [7:1] zero
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PKB_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_UPD,
    ST_HOLD
  } state_t;

  state_t               state_r;
  logic                 out_tvalid_r;
  logic                 out_hit_r;
  logic                 hit_r;
  logic [PKB_W-1:0]     page_kb_r;
  logic [CAP_CFG_W-1:0] cap_cfg_r;
  logic [PKB_W-1:0]     divisor;
  logic                 start;
  logic                 div_done;
  logic                 cam_hit;
  logic [TAG_W-1:0]     vpn;
  ltht_cmd_t            cmd;

  assign in_tready  = (state_r == ST_IDLE);
  assign start      = in_tvalid && in_tready;
  assign divisor    = (page_kb_r == '0) ? PKB_W'(1) : page_kb_r;
  assign cmd.lookup = (state_r == ST_LOOK);
  assign cmd.update = (state_r == ST_UPD);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_hit_r};
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_kb_r <= PAGE_KB_RESET;
      cap_cfg_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAGE_SIZE_KB:   page_kb_r <= cfg_data;
        CFG_ENTRIES_IN_USE: cap_cfg_r <= cfg_data[CAP_CFG_W-1:0];
        default:            ;
      endcase
    end
  end

  ltht_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (start),
    .dividend_i (in_tdata[ADDR_W-1:PAGE_OFS]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (vpn)
  );

  ltht_cam #(
    .ENTRIES (ENTRIES)
  ) u_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .vpn_i     (vpn),
    .cap_cfg_i (cap_cfg_r),
    .hit_o     (cam_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if ((state_r == ST_HOLD) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          hit_r   <= cam_hit;
          state_r <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!out_tvalid_r || out_tready) begin
            out_hit_r <= hit_r;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_HOLD))
    else $error("result raised outside the hold state");
`endif

endmodule

// ===== sv/ltht_div.sv =====
// ----------------------------------------------------------------------------
// ltht_div
// Serial restoring divider: one quotient bit per cycle through one subtractor.
// ----------------------------------------------------------------------------
module ltht_div
  import ltht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [TAG_W-1:0] dividend_i,
  input  logic [PKB_W-1:0] divisor_i,
  output logic             done_o,
  output logic [TAG_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(TAG_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PKB_W:0]   rem_r;
  logic [PKB_W:0]   rem_nxt;
  logic [TAG_W-1:0] quo_r;
  logic [PKB_W-1:0] dsr_r;
  logic [PKB_W:0]   trial;
  logic             ge;

  always_comb begin
    trial   = {rem_r[PKB_W-1:0], quo_r[TAG_W-1]};
    ge      = (trial >= {1'b0, dsr_r});
    rem_nxt = ge ? (trial - {1'b0, dsr_r}) : trial;
  end

  assign done_o     = busy_r && (cnt_r == CNT_W'(TAG_W - 1));
  assign quotient_o = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      busy_r <= !done_o;
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      dsr_r <= divisor_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[TAG_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== sv/ltht_cam.sv =====
// ----------------------------------------------------------------------------
// ltht_cam
// Tag cells with per-entry compare, LRU ranks and occupancy count.
// ----------------------------------------------------------------------------
module ltht_cam
  import ltht_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ltht_cmd_t            cmd_i,
  input  logic [TAG_W-1:0]     vpn_i,
  input  logic [CAP_CFG_W-1:0] cap_cfg_i,
  output logic                 hit_o
);

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [TAG_W-1:0]   tag_r   [ENTRIES];
  logic [RW-1:0]      rank_r  [ENTRIES];
  logic [RW-1:0]      rank_nxt[ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [ENTRIES-1:0] match_r;
  logic [ENTRIES-1:0] match_nxt;
  logic [ENTRIES-1:0] ev;
  logic [ENTRIES-1:0] valid_mid;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] ins;
  logic [CW-1:0]      occ_r;
  logic [CW-1:0]      occ_nxt;
  logic [CW-1:0]      occ_last;
  logic [CW-1:0]      cap;
  logic [RW-1:0]      hit_rank;
  logic               hit;
  logic               evict;

  always_comb begin
    if (cap_cfg_i == '0) begin
      cap = CW'(1);
    end else if (32'(cap_cfg_i) > ENTRIES) begin
      cap = CW'(ENTRIES);
    end else begin
      cap = CW'(cap_cfg_i);
    end

    hit      = |match_r;
    evict    = (occ_r >= cap);
    occ_last = occ_r - CW'(1);
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (tag_r[i] == vpn_i);
      hit_rank     = hit_rank | (match_r[i] ? rank_r[i] : '0);
      ev[i]        = evict && valid_r[i] && (CW'(rank_r[i]) == occ_last);
    end
    valid_mid = valid_r & ~ev;
    free      = ~valid_mid;
    ins       = free & (~free + ENTRIES'(1));

    if (hit) begin
      valid_nxt = valid_r;
      occ_nxt   = occ_r;
      for (int i = 0; i < ENTRIES; i++) begin
        if (match_r[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end else begin
          rank_nxt[i] = rank_r[i];
        end
      end
    end else begin
      valid_nxt = valid_mid | ins;
      occ_nxt   = (evict && (occ_r != '0)) ? occ_r : (occ_r + CW'(1));
      for (int i = 0; i < ENTRIES; i++) begin
        if (ins[i] || ev[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_mid[i]) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end else begin
          rank_nxt[i] = rank_r[i];
        end
      end
    end
  end

  assign hit_o = hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      match_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cmd_i.lookup) begin
        match_r <= match_nxt;
      end
      if (cmd_i.update) begin
        valid_r <= valid_nxt;
        occ_r   <= occ_nxt;
        for (int i = 0; i < ENTRIES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd_i.update && !hit && ins[i]) begin
        tag_r[i] <= vpn_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(occ_r))
    else $error("occupancy count disagrees with valid entries");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_r))
    else $error("more than one entry matched the page");

  a_room_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.update && !hit) |-> (ins != '0))
    else $error("miss found no free entry after eviction");
`endif

endmodule
